FILE: hw/rtl/drrb_pkg.sv
// ----------------------------------------------------------------------------
// drrb_pkg
// shared constants, codes and control types of the delimited record ring buffer
// ----------------------------------------------------------------------------
package drrb_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int BYTE_W    = 8;
    localparam int RESV_W    = 7;
    localparam int LEN_W     = 6;
    localparam int STAT_W    = 3;
    localparam int RCNT_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W     = 8;

    localparam logic [BYTE_W-1:0] TERM_RESET    = 8'd13;
    localparam logic [RESV_W-1:0] RESERVE_RESET = 7'd32;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_REC    = 2'd1,
        CMD_BYTES  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DATA      = 3'd0,
        ST_PUSH_OK   = 3'd1,
        ST_DROP_RES  = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NO_REC    = 3'd4,
        ST_DROP_FULL = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TERM    = 1'b0,
        REG_RESERVE = 1'b1
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic    do_push;
        logic    load_status;
        t_status status_code;
        logic    start_scan;
        logic    scan_step;
        logic    rd_scan;
        logic    rd_emit;
        logic    commit_rec;
        logic    term_only;
        logic    start_bytes;
        logic    emit_byte;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic held_zero;
        logic out_free;
        logic scan_match;
        logic scan_end;
        logic cnt_zero;
        logic rem_last;
        logic rcount_zero;
    } t_sts;

    function automatic logic [ADDR_W-1:0] ptr_next(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: hw/rtl/delimited_record_ring_buffer.sv
// ----------------------------------------------------------------------------
// delimited_record_ring_buffer
// byte ring fed by a scanner, read as terminated records or as raw bytes
// ----------------------------------------------------------------------------
// input channel i_valid/o_ready carries one command per transaction:
//   push byte, read one record, or read up to i_read_count bytes
// output channel o_valid/i_ready carries one result per transaction,
//   o_last marks the final result of a command
// pushes may follow each other every cycle while the result register is free
// a record read scans byte by byte up to the terminator (one ring read and one
//   compare each), then returns each byte (one ring read and one result load)
// a bytes read returns each byte with one ring read and one result load
// the ring has a single read port with registered data
// a new command is taken only while idle with the result register empty or read
// a stalled receiver holds the result; emission and input wait, no data is lost
// configuration port writes terminator byte (index 0) and write reserve
//   (index 1); the user must write only while idle; the block does not check
// synchronous active-low reset empties the ring and restores the defaults
//   (terminator 13, reserve 32); no clearing pass is needed
// ----------------------------------------------------------------------------
module delimited_record_ring_buffer import drrb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_burst_start,
    input  logic [RCNT_W-1:0]    i_read_count,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic [STAT_W-1:0]    o_status,
    output logic                 o_last,
    output logic [LEN_W-1:0]     o_record_length,
    output logic [CNT_W-1:0]     o_fill_level
);

    t_ctl ctl;
    t_sts sts;

    drrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (t_cmd'(i_cmd)),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_ctl   (ctl)
    );

    drrb_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data      (i_cfg_data),
        .i_data_byte     (i_data_byte),
        .i_burst_start   (i_burst_start),
        .i_read_count    (i_read_count),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_out_byte      (o_out_byte),
        .o_status        (o_status),
        .o_last          (o_last),
        .o_record_length (o_record_length),
        .o_fill_level    (o_fill_level)
    );

endmodule

FILE: hw/rtl/drrb_ctrl.sv
// ----------------------------------------------------------------------------
// drrb_ctrl
// command sequencer: accepts transactions, runs the record scan and byte emission
// ----------------------------------------------------------------------------
module drrb_ctrl import drrb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    input  t_sts i_sts,
    output logic o_ready,
    output t_ctl o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN_RD  = 5'b00010,
        S_SCAN_CMP = 5'b00100,
        S_EMIT_RD  = 5'b01000,
        S_EMIT_OUT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.status_code = ST_DATA;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_PUSH: begin
                            o_ctl.do_push = 1'b1;
                        end
                        CMD_REC: begin
                            if (i_sts.held_zero) begin
                                o_ctl.load_status = 1'b1;
                                o_ctl.status_code = ST_EMPTY;
                            end else begin
                                o_ctl.start_scan = 1'b1;
                                n_state = S_SCAN_RD;
                            end
                        end
                        CMD_BYTES: begin
                            if (!i_sts.rcount_zero) begin
                                if (i_sts.held_zero) begin
                                    o_ctl.load_status = 1'b1;
                                    o_ctl.status_code = ST_EMPTY;
                                end else begin
                                    o_ctl.start_bytes = 1'b1;
                                    n_state = S_EMIT_RD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                o_ctl.rd_scan = 1'b1;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.scan_match) begin
                    if (i_sts.cnt_zero) begin
                        if (i_sts.out_free) begin
                            o_ctl.term_only = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_ctl.commit_rec = 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end else if (i_sts.scan_end) begin
                    if (i_sts.out_free) begin
                        o_ctl.load_status = 1'b1;
                        o_ctl.status_code = ST_NO_REC;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_ctl.scan_step = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_EMIT_RD: begin
                o_ctl.rd_emit = 1'b1;
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit_byte = 1'b1;
                    n_state = i_sts.rem_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/drrb_dpath.sv
// ----------------------------------------------------------------------------
// drrb_dpath
// byte ring, pointers, fill count, configuration and result register
// ----------------------------------------------------------------------------
module drrb_dpath import drrb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_burst_start,
    input  logic [RCNT_W-1:0]    i_read_count,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic [STAT_W-1:0]    o_status,
    output logic                 o_last,
    output logic [LEN_W-1:0]     o_record_length,
    output logic [CNT_W-1:0]     o_fill_level
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    logic [BYTE_W-1:0] r_term;
    logic [RESV_W-1:0] r_reserve;
    logic [ADDR_W-1:0] r_rp, n_rp;
    logic [ADDR_W-1:0] r_wp;
    logic [CNT_W-1:0]  r_held, n_held;
    logic              r_drop, n_drop;
    logic [ADDR_W-1:0] r_scan_ptr;
    logic [ADDR_W-1:0] r_scan_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic              r_skip;
    logic [LEN_W-1:0]  r_rlen;

    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    t_status           r_o_status;
    logic              r_o_last;
    logic [LEN_W-1:0]  r_o_rlen;
    logic [CNT_W-1:0]  r_o_fill;

    logic [CNT_W-1:0]  free_space;
    logic              push_write;
    t_status           push_status;
    logic [CNT_W-1:0]  bytes_n;
    logic              out_load;
    logic [BYTE_W-1:0] n_o_byte;
    t_status           n_o_status;
    logic [LEN_W-1:0]  n_o_rlen;

    assign free_space = CNT_W'(DEPTH) - r_held;
    assign bytes_n    = (CMP_W'(i_read_count) < CMP_W'(r_held))
                        ? CNT_W'(i_read_count) : r_held;

    always_comb begin
        n_drop      = r_drop;
        push_write  = 1'b0;
        push_status = ST_PUSH_OK;
        if (i_burst_start) begin
            n_drop = CMP_W'(free_space) < CMP_W'(r_reserve);
        end
        if (n_drop) begin
            push_status = ST_DROP_RES;
        end else if (r_held == CNT_W'(DEPTH)) begin
            push_status = ST_DROP_FULL;
        end else begin
            push_write = 1'b1;
        end
    end

    always_comb begin
        n_held = r_held;
        n_rp   = r_rp;
        if (i_ctl.do_push && push_write) begin
            n_held = r_held + 1'b1;
        end
        if (i_ctl.commit_rec || i_ctl.term_only) begin
            n_held = r_held - CNT_W'(r_scan_cnt) - 1'b1;
        end
        if (i_ctl.start_bytes) begin
            n_held = r_held - bytes_n;
        end
        if (i_ctl.term_only) begin
            n_rp = ptr_next(r_rp);
        end
        if (i_ctl.emit_byte) begin
            n_rp = (o_sts.rem_last && r_skip) ? ptr_next(ptr_next(r_rp)) : ptr_next(r_rp);
        end
    end

    assign out_load = i_ctl.do_push || i_ctl.load_status || i_ctl.term_only
                      || i_ctl.emit_byte;

    always_comb begin
        n_o_byte   = '0;
        n_o_rlen   = '0;
        n_o_status = ST_DATA;
        priority if (i_ctl.do_push) begin
            n_o_status = push_status;
        end else if (i_ctl.load_status) begin
            n_o_status = i_ctl.status_code;
        end else if (i_ctl.emit_byte) begin
            n_o_byte = r_rd_data;
            n_o_rlen = r_rlen;
        end else begin
        end
    end

    always_comb begin
        o_sts.held_zero   = (r_held == '0);
        o_sts.out_free    = !r_o_valid || i_out_ready;
        o_sts.scan_match  = (r_rd_data == r_term);
        o_sts.scan_end    = (CNT_W'(r_scan_cnt) + 1'b1 == r_held);
        o_sts.cnt_zero    = (r_scan_cnt == '0);
        o_sts.rem_last    = (r_rem == CNT_W'(1));
        o_sts.rcount_zero = (i_read_count == '0);
    end

    // ring storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.do_push && push_write) begin
            r_mem[r_wp] <= i_data_byte;
        end
        if (i_ctl.rd_scan || i_ctl.rd_emit) begin
            r_rd_data <= r_mem[i_ctl.rd_scan ? r_scan_ptr : r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term    <= TERM_RESET;
            r_reserve <= RESERVE_RESET;
            r_rp      <= '0;
            r_wp      <= '0;
            r_held    <= '0;
            r_drop    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TERM:    r_term    <= i_cfg_data;
                    REG_RESERVE: r_reserve <= RESV_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
            r_rp   <= n_rp;
            r_held <= n_held;
            if (i_ctl.do_push) begin
                r_drop <= n_drop;
                if (push_write) begin
                    r_wp <= ptr_next(r_wp);
                end
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start_scan) begin
            r_scan_ptr <= r_rp;
            r_scan_cnt <= '0;
        end else if (i_ctl.scan_step) begin
            r_scan_ptr <= ptr_next(r_scan_ptr);
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
        if (i_ctl.commit_rec) begin
            r_rem  <= CNT_W'(r_scan_cnt);
            r_skip <= 1'b1;
            r_rlen <= LEN_W'(r_scan_cnt);
        end else if (i_ctl.start_bytes) begin
            r_rem  <= bytes_n;
            r_skip <= 1'b0;
            r_rlen <= '0;
        end else if (i_ctl.emit_byte) begin
            r_rem  <= r_rem - 1'b1;
        end
        if (out_load) begin
            r_o_byte   <= n_o_byte;
            r_o_status <= n_o_status;
            r_o_last   <= !i_ctl.emit_byte || o_sts.rem_last;
            r_o_rlen   <= n_o_rlen;
            r_o_fill   <= n_held;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_out_byte      = r_o_byte;
    assign o_status        = r_o_status;
    assign o_last          = r_o_last;
    assign o_record_length = r_o_rlen;
    assign o_fill_level    = r_o_fill;

endmodule
